@@ rtl/core/ccsb_pkg.sv @@
// ----------------------------------------------------------------------------
// ccsb_pkg
// Shared types and constants of the character cell sprite blitter.
// ----------------------------------------------------------------------------
package ccsb_pkg;

  // command codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BLIT  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // colour blend modes
  localparam logic [1:0] BM_COPY = 2'd0;
  localparam logic [1:0] BM_OR   = 2'd1;
  localparam logic [1:0] BM_XOR  = 2'd2;
  localparam logic [1:0] BM_ADD  = 2'd3;

  // sprite character that leaves the destination character alone
  localparam logic [15:0] KEEP_CHAR = 16'h002B;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] span_x;
    logic signed [15:0] span_y;
    logic [9:0]         cell_index;
    logic [15:0]        cell_char;
    logic [7:0]         cell_color;
    logic [1:0]         blend_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  done_kind;
    logic [15:0] read_char;
    logic [7:0]  read_color;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_DIV,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  typedef struct packed {
    logic capture;
    logic sp_we;
    logic emit;
    logic out_read;
    logic base_load;
    logic div_step;
    logic clr_step;
    logic clr_zero;
    logic cell_wr;
    logic cell_adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       skip;
    logic       col_last;
    logic       row_last;
    logic       div_last;
    logic       clr_last;
  } dp_status_t;

endpackage

@@ rtl/core/ccsb_ram.sv @@
// ----------------------------------------------------------------------------
// ccsb_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ccsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/ccsb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccsb_ctrl
// Command sequencer: steps the datapath through clear, blit and read.
// ----------------------------------------------------------------------------
module ccsb_ctrl
  import ccsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] opcode,
  output logic       busy,
  output ctrl_cmd_t  cmd,
  input  dp_status_t status
);

  state_t state_r;
  state_t state_nxt;
  logic   walk_done;

  assign walk_done = status.col_last && status.row_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        cmd.clr_zero = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (opcode)
            OP_LOAD: begin
              cmd.sp_we = 1'b1;
              cmd.emit  = 1'b1;
            end
            OP_CLEAR: state_nxt = ST_CLEAR;
            default:  state_nxt = ST_SETUP;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SETUP: begin
        cmd.base_load = 1'b1;
        if (status.op == OP_READ) begin
          state_nxt = ST_RD_ADDR;
        end else if (status.empty) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_CELL_RD;
        end
      end
      ST_CELL_RD: begin
        if (status.skip) begin
          cmd.cell_adv = 1'b1;
          if (walk_done) begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_CELL_WR;
        end
      end
      ST_CELL_WR: begin
        cmd.cell_wr  = 1'b1;
        cmd.cell_adv = 1'b1;
        if (walk_done) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_CELL_RD;
        end
      end
      ST_RD_ADDR: state_nxt = ST_RD_DATA;
      ST_RD_DATA: begin
        cmd.emit     = 1'b1;
        cmd.out_read = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTH
  a_idle_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && cmd.emit) |-> (start && opcode == OP_LOAD))
    else $error("result issued from idle without a load");

  a_long_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start && opcode != OP_LOAD) |=> busy)
    else $error("multi-cycle command did not raise busy");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CELL_WR) |-> ($past(state_r) == ST_CELL_RD))
    else $error("cell write without preceding cell read");

  a_init_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !cmd.emit)
    else $error("result issued during power-up clear");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !status.div_last) |=> (state_r == ST_DIV))
    else $error("width reduction left early");
`endif

endmodule

@@ rtl/core/ccsb_dp.sv @@
// ----------------------------------------------------------------------------
// ccsb_dp
// Datapath: frame and sprite stores, walk counters, width reduction, blend.
// ----------------------------------------------------------------------------
module ccsb_dp
  import ccsb_pkg::*;
#(
  parameter int COLS         = 128,
  parameter int ROWS         = 32,
  parameter int SPRITE_CELLS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int CELLS = COLS * ROWS;
  localparam int FAW   = $clog2(CELLS);
  localparam int FBW   = $clog2(CELLS + 1);
  localparam int XW    = $clog2(COLS + 1);
  localparam int YW    = $clog2(ROWS + 1);
  localparam int SW    = $clog2(SPRITE_CELLS);

  // limits a signed sum to [0, hi]
  function automatic int clamp_lim(input logic signed [16:0] v, input int hi);
    if (int'(v) < 0) begin
      return 0;
    end else if (int'(v) > hi) begin
      return hi;
    end else begin
      return int'(v);
    end
  endfunction

  // narrow modulo by compare and subtract of shifted sprite store sizes
  function automatic logic [SW-1:0] idx_mod(input logic [9:0] v);
    logic [31:0] r;
    r = {22'd0, v};
    for (int k = 6; k >= 0; k--) begin
      if (r >= (32'(SPRITE_CELLS) << k)) begin
        r = r - (32'(SPRITE_CELLS) << k);
      end
    end
    return SW'(r);
  endfunction

  // four compare and subtract steps of the width reduction, group grp
  // covers shifts 4*grp+3 down to 4*grp
  function automatic logic [15:0] mod_quad(input logic [15:0] v, input logic [1:0] grp);
    logic [31:0] r;
    logic [31:0] m;
    r = {16'd0, v};
    for (int j = 3; j >= 0; j--) begin
      m = 32'(SPRITE_CELLS) << (4 * int'(grp) + j);
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[15:0];
  endfunction

  // captured command
  logic [1:0]     op_r;
  logic [1:0]     mode_r;
  logic [7:0]     color_r;
  logic [15:0]    char_r;
  logic [XW-1:0]  xb_r, xe_r, x_r;
  logic [YW-1:0]  ye_r, y_r;
  logic           dxp_r, dyp_r;
  logic           rd_ok_r;
  logic           empty_r;
  // walk state
  logic [FBW-1:0] fbase_r;
  logic [SW-1:0]  rem_r;
  logic [15:0]    wsh_r;
  logic [1:0]     div_cnt_r;
  logic [SW-1:0]  rs_r, src_r;
  logic [FAW-1:0] clr_cnt_r;
  logic           out_valid_r;
  out_item_t      out_r;

  // accept-time bounds
  logic signed [16:0] xe_sum, ye_sum;
  logic [XW-1:0]      xb_c, xe_c;
  logic [YW-1:0]      yb_c, ye_c;
  logic [15:0]        wabs;
  logic               rd_ok_c;

  assign xe_sum  = 17'(in_data.pos_x) + 17'(in_data.span_x);
  assign ye_sum  = 17'(in_data.pos_y) + 17'(in_data.span_y);
  assign xb_c    = XW'(clamp_lim(17'(in_data.pos_x), COLS));
  assign xe_c    = XW'(clamp_lim(xe_sum, COLS));
  assign yb_c    = YW'(clamp_lim(17'(in_data.pos_y), ROWS));
  assign ye_c    = YW'(clamp_lim(ye_sum, ROWS));
  assign wabs    = in_data.span_x[15] ? 16'(~in_data.span_x + 16'd1) : in_data.span_x;
  assign rd_ok_c = !in_data.pos_x[15] && (int'(in_data.pos_x) < COLS) &&
                   !in_data.pos_y[15] && (int'(in_data.pos_y) < ROWS);

  // walk arithmetic
  logic [XW-1:0]  x_step;
  logic [YW-1:0]  y_step;
  logic [SW:0]    rs_sum, src_inc;
  logic [SW-1:0]  rs_nxt, src_nxt;
  logic [15:0]    wsh_nxt;
  logic [FBW-1:0] cell_sum;
  logic [FAW-1:0] fr_addr;

  assign x_step   = dxp_r ? x_r + 1'b1 : x_r - 1'b1;
  assign y_step   = dyp_r ? y_r + 1'b1 : y_r - 1'b1;
  assign wsh_nxt  = mod_quad(wsh_r, ~div_cnt_r);
  assign rs_sum   = {1'b0, rs_r} + {1'b0, rem_r};
  assign rs_nxt   = (rs_sum >= (SW+1)'(SPRITE_CELLS)) ?
                    SW'(rs_sum - (SW+1)'(SPRITE_CELLS)) : SW'(rs_sum);
  assign src_inc  = {1'b0, src_r} + 1'b1;
  assign src_nxt  = (src_inc == (SW+1)'(SPRITE_CELLS)) ? '0 : SW'(src_inc);
  assign cell_sum = fbase_r + FBW'(x_r);
  assign fr_addr  = cmd.clr_step ? clr_cnt_r : FAW'(cell_sum);

  // stores
  logic [23:0] fr_q, fr_wdata;
  logic [15:0] sp_q;
  logic [15:0] new_char;
  logic [7:0]  new_color, blend;

  always_comb begin
    case (mode_r)
      BM_COPY: blend = color_r;
      BM_OR:   blend = fr_q[7:0] | color_r;
      BM_XOR:  blend = fr_q[7:0] ^ color_r;
      BM_ADD:  blend = fr_q[7:0] + color_r;
      default: blend = color_r;
    endcase
  end

  assign new_char  = (sp_q == KEEP_CHAR) ? fr_q[23:8] : sp_q;
  assign new_color = (sp_q == 16'd0) ? fr_q[7:0] : blend;

  always_comb begin
    if (cmd.clr_step) begin
      fr_wdata = cmd.clr_zero ? 24'd0 : {char_r, color_r};
    end else begin
      fr_wdata = {new_char, new_color};
    end
  end

  ccsb_ram #(
    .WIDTH (24),
    .DEPTH (CELLS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (cmd.clr_step | cmd.cell_wr),
    .waddr (fr_addr),
    .wdata (fr_wdata),
    .raddr (fr_addr),
    .rdata (fr_q)
  );

  ccsb_ram #(
    .WIDTH (16),
    .DEPTH (SPRITE_CELLS)
  ) u_sprite_ram (
    .clk   (clk),
    .we    (cmd.sp_we),
    .waddr (idx_mod(in_data.cell_index)),
    .wdata (in_data.cell_char),
    .raddr (src_r),
    .rdata (sp_q)
  );

  // command capture and walk registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_data.opcode;
      mode_r    <= in_data.blend_mode;
      color_r   <= in_data.cell_color;
      char_r    <= in_data.cell_char;
      xb_r      <= xb_c;
      xe_r      <= xe_c;
      ye_r      <= ye_c;
      dxp_r     <= (xb_c < xe_c);
      dyp_r     <= (yb_c < ye_c);
      empty_r   <= (xb_c == xe_c) || (yb_c == ye_c);
      rd_ok_r   <= rd_ok_c;
      x_r       <= (in_data.opcode == OP_READ) ? XW'(in_data.pos_x) : xb_c;
      y_r       <= (in_data.opcode == OP_READ) ? YW'(in_data.pos_y) : yb_c;
      rem_r     <= '0;
      wsh_r     <= wabs;
      div_cnt_r <= '0;
      rs_r      <= '0;
      src_r     <= '0;
    end else begin
      if (cmd.base_load) begin
        fbase_r <= FBW'(int'(y_r) * COLS);
      end
      if (cmd.div_step) begin
        rem_r     <= SW'(wsh_nxt);
        wsh_r     <= wsh_nxt;
        div_cnt_r <= div_cnt_r + 2'd1;
      end
      if (cmd.cell_adv) begin
        if (status.col_last) begin
          // next row: restart column and source at the new row base
          x_r     <= xb_r;
          y_r     <= y_step;
          fbase_r <= dyp_r ? fbase_r + FBW'(COLS) : fbase_r - FBW'(COLS);
          rs_r    <= rs_nxt;
          src_r   <= rs_nxt;
        end else begin
          x_r   <= x_step;
          src_r <= src_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.clr_step) begin
        clr_cnt_r <= status.clr_last ? '0 : clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.done_kind  <= cmd.capture ? in_data.opcode : op_r;
      out_r.read_char  <= (cmd.out_read && rd_ok_r) ? fr_q[23:8] : 16'd0;
      out_r.read_color <= (cmd.out_read && rd_ok_r) ? fr_q[7:0] : 8'd0;
    end
  end

  assign status.op       = op_r;
  assign status.empty    = empty_r;
  assign status.skip     = (x_r == XW'(COLS)) || (y_r == YW'(ROWS));
  assign status.col_last = (x_step == xe_r);
  assign status.row_last = (y_step == ye_r);
  assign status.div_last = (div_cnt_r == 2'd3);
  assign status.clr_last = (clr_cnt_r == FAW'(CELLS - 1));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/char_cell_sprite_blitter.sv @@
// ----------------------------------------------------------------------------
// char_cell_sprite_blitter
// Text-cell frame store with sprite store and clipped, blended blitter.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown on out_data for one cycle with out_valid high,
// which the receiver must take as it comes. A sprite load does not raise
// busy, so the next command may follow at once. A read holds busy through
// the setup state (row base multiply), then the registered frame read. A
// clear writes one frame cell per cycle over all COLS*ROWS cells; the same
// sweep runs after reset, writing zeros, before the first command is taken.
// A blit holds busy through a setup state, returning to idle there for an
// empty box, then reduces the sprite width modulo SPRITE_CELLS, four compare
// and subtract steps per cycle, then reads and read-modify-writes each visible
// cell through the single frame port; a clipped edge cell gets the read state
// only.
// ----------------------------------------------------------------------------
module char_cell_sprite_blitter
  import ccsb_pkg::*;
#(
  parameter int COLS         = 128,
  parameter int ROWS         = 32,
  parameter int SPRITE_CELLS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ccsb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_data.opcode),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  ccsb_dp #(
    .COLS         (COLS),
    .ROWS         (ROWS),
    .SPRITE_CELLS (SPRITE_CELLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
